[hw/rtl/timed_frame_crossfade_blender_defines.svh]
// ----------------------------------------------------------------------------
// Timed frame crossfade blender assertion macros
// Shared concurrent assertion forms for the blender RTL.
// ----------------------------------------------------------------------------
`ifndef TIMED_FRAME_CROSSFADE_BLENDER_DEFINES_SVH
`define TIMED_FRAME_CROSSFADE_BLENDER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TFCB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TFCB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/tfcb_pkg.sv]
// ----------------------------------------------------------------------------
// Timed frame crossfade blender package
// Widths, codes, item and control types and the channel lerp function.
// ----------------------------------------------------------------------------
`default_nettype none

package tfcb_pkg;

    localparam int MAX_FRAMES_DEF = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int TIME_W     = 20;
    localparam int FC_W       = 5;
    localparam int ELAPSED_W  = 16;
    localparam int TIMER_W    = 21;
    localparam int DIFF_W     = TIMER_W + 1;
    localparam int PIX_W      = 32;
    localparam int CHAN_W     = 8;
    localparam int CHANNELS   = PIX_W / CHAN_W;
    localparam int WEIGHT_W   = 9;
    localparam int IDX_OUT_W  = 4;
    localparam int DIV_STEPS  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FCOUNT = 2'd2;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    localparam logic [TIME_W-1:0]   CYCLE_RST  = 20'd4096;
    localparam logic [TIME_W-1:0]   BLEND_RST  = 20'd1024;
    localparam logic [FC_W-1:0]     FCOUNT_RST = 5'd4;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

    typedef struct packed {
        logic                 func;
        logic [ELAPSED_W-1:0] elapsed;
        logic [PIX_W-1:0]     pixel_current;
        logic [PIX_W-1:0]     pixel_next;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0]     blended_pixel;
        logic [WEIGHT_W-1:0]  blend_weight;
        logic [IDX_OUT_W-1:0] current_index;
        logic [IDX_OUT_W-1:0] next_index;
    } t_out_item;

    typedef struct packed {
        logic out_pixel;
        logic out_hold;
        logic load_sum;
        logic eval;
        logic commit_wrap;
        logic commit_zero;
        logic start_div;
        logic div_step;
        logic div_last;
    } t_cmd;

    typedef struct packed {
        logic multi;
        logic wrap;
        logic over_neg;
    } t_stat;

    function automatic logic [CHAN_W-1:0] lerp_channel(input logic [CHAN_W-1:0]   ca,
                                                       input logic [CHAN_W-1:0]   cb,
                                                       input logic [WEIGHT_W-1:0] w);
        logic [WEIGHT_W-1:0] inv;
        logic [16:0]         acc;
        inv = WEIGHT_ONE - w;
        acc = 17'(ca) * 17'(inv) + 17'(cb) * 17'(w);
        return acc[15:8];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/tfcb_if.sv]
// ----------------------------------------------------------------------------
// Timed frame crossfade blender channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfcb_in_if import tfcb_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tfcb_out_if import tfcb_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/tfcb_ctrl.sv]
// ----------------------------------------------------------------------------
// Timed frame crossfade blender controller
// Sequences tick evaluation and the weight division, and owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "timed_frame_crossfade_blender_defines.svh"

module tfcb_ctrl import tfcb_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_in_func,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_stat i_stat,
    output t_cmd      o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_OVER = 2'd2;
    localparam logic [1:0] S_DIV  = 2'd3;

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             w_accept;
    logic             w_load_out;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_load_out  = o_cmd.out_pixel || o_cmd.out_hold || o_cmd.commit_wrap ||
                         o_cmd.commit_zero || o_cmd.div_last;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_func == FUNC_PIXEL) begin
                        o_cmd.out_pixel = 1'b1;
                    end else if (!i_stat.multi) begin
                        o_cmd.out_hold = 1'b1;
                    end else begin
                        o_cmd.load_sum = 1'b1;
                        n_state        = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_OVER;
            end
            S_OVER: begin
                if (i_stat.wrap) begin
                    o_cmd.commit_wrap = 1'b1;
                    n_state           = S_IDLE;
                end else if (i_stat.over_neg) begin
                    o_cmd.commit_zero = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    o_cmd.start_div = 1'b1;
                    n_cnt           = '0;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_LAST) begin
                    o_cmd.div_last = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        n_out_valid = w_load_out ? 1'b1 : (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    `TFCB_ASSERT_NOW(a_no_accept_when_full, i_clk, i_rst_n, r_out_valid && !i_out_ready, !w_accept, "input transfer taken while result is stalled")
    `TFCB_ASSERT_NEXT(a_div_ends_with_result, i_clk, i_rst_n, (r_state == S_DIV) && (r_cnt == CNT_LAST), (r_state == S_IDLE) && r_out_valid, "division did not end with a result")
    `TFCB_ASSERT_NEXT(a_over_resolves, i_clk, i_rst_n, r_state == S_OVER, (r_state == S_DIV) || r_out_valid, "tick evaluation left without result or division")

endmodule

`default_nettype wire

[hw/rtl/tfcb_datapath.sv]
// ----------------------------------------------------------------------------
// Timed frame crossfade blender datapath
// Configuration, frame timer and indices, weight divider, lerp and result.
// ----------------------------------------------------------------------------
`default_nettype none

module tfcb_datapath import tfcb_pkg::*; #(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire t_in_item              i_in_data,
    input  wire t_cmd                  i_cmd,
    output t_stat                      o_stat,
    output t_out_item                  o_out_data
);

    localparam int IDX_W = $clog2(MAX_FRAMES);
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);

    function automatic logic [CNT_W-1:0] eff_count(input logic [FC_W-1:0] fc);
        logic [CNT_W-1:0] n;
        if (int'(fc) > MAX_FRAMES) begin
            n = CNT_W'(MAX_FRAMES);
        end else if (fc == '0) begin
            n = CNT_W'(1);
        end else begin
            n = CNT_W'(fc);
        end
        return n;
    endfunction

    logic [TIME_W-1:0]   r_cycle, n_cycle;
    logic [TIME_W-1:0]   r_blend, n_blend;
    logic [FC_W-1:0]     r_fc, n_fc;
    logic [TIMER_W-1:0]  r_timer, n_timer;
    logic [WEIGHT_W-1:0] r_weight, n_weight;
    logic [IDX_W-1:0]    r_cur, n_cur;
    logic [IDX_W-1:0]    r_next, n_next;

    logic [TIMER_W-1:0]  r_sum, n_sum;
    logic [DIFF_W-1:0]   r_diff, n_diff;
    logic [TIME_W-1:0]   r_rem, n_rem;
    logic [7:0]          r_quot, n_quot;
    t_out_item           r_out, n_out;

    logic [CNT_W-1:0]    w_count;
    logic [CNT_W-1:0]    w_new_count;
    logic [CNT_W:0]      w_next_inc;
    logic [IDX_W-1:0]    w_next_adv;
    logic [DIFF_W-1:0]   w_sum_raw;
    logic [TIMER_W-1:0]  w_sum_sat;
    logic [DIFF_W-1:0]   w_over;
    logic [TIME_W:0]     w_rem_sh;
    logic                w_ge;
    logic [TIME_W-1:0]   w_rem_step;
    logic [7:0]          w_quot_step;
    logic [PIX_W-1:0]    w_lerp;
    logic                w_load_out;

    assign w_count     = eff_count(r_fc);
    assign w_new_count = eff_count(i_cfg_data[FC_W-1:0]);
    assign w_next_inc  = (CNT_W + 1)'(r_next) + 1'b1;
    assign w_next_adv  = (w_next_inc == (CNT_W + 1)'(w_count)) ? '0 : IDX_W'(w_next_inc);

    assign w_sum_raw = DIFF_W'(r_timer) + DIFF_W'(i_in_data.elapsed);
    assign w_sum_sat = w_sum_raw[DIFF_W-1] ? '1 : w_sum_raw[TIMER_W-1:0];
    assign w_over    = r_diff + DIFF_W'(r_blend);

    assign w_rem_sh    = {r_rem, 1'b0};
    assign w_ge        = w_rem_sh >= (TIME_W + 1)'(r_blend);
    assign w_rem_step  = w_ge ? TIME_W'(w_rem_sh - (TIME_W + 1)'(r_blend)) : w_rem_sh[TIME_W-1:0];
    assign w_quot_step = {r_quot[6:0], w_ge};

    assign o_stat.multi    = w_count > CNT_W'(1);
    assign o_stat.wrap     = !r_diff[DIFF_W-1];
    assign o_stat.over_neg = w_over[DIFF_W-1];
    assign o_out_data      = r_out;

    assign w_load_out = i_cmd.out_pixel || i_cmd.out_hold || i_cmd.commit_wrap ||
                        i_cmd.commit_zero || i_cmd.div_last;

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            w_lerp[c*CHAN_W +: CHAN_W] = lerp_channel(i_in_data.pixel_current[c*CHAN_W +: CHAN_W],
                                                      i_in_data.pixel_next[c*CHAN_W +: CHAN_W],
                                                      r_weight);
        end
    end

    always_comb begin
        n_cycle  = r_cycle;
        n_blend  = r_blend;
        n_fc     = r_fc;
        n_timer  = r_timer;
        n_weight = r_weight;
        n_cur    = r_cur;
        n_next   = r_next;
        n_sum    = r_sum;
        n_diff   = r_diff;
        n_rem    = r_rem;
        n_quot   = r_quot;
        n_out    = r_out;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CYCLE: n_cycle = i_cfg_data[TIME_W-1:0];
                CFG_BLEND: n_blend = i_cfg_data[TIME_W-1:0];
                CFG_FCOUNT: begin
                    if (i_cfg_data[FC_W-1:0] != r_fc) begin
                        n_fc     = i_cfg_data[FC_W-1:0];
                        n_timer  = '0;
                        n_weight = '0;
                        n_cur    = '0;
                        n_next   = (w_new_count > CNT_W'(1)) ? IDX_W'(1) : '0;
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.load_sum) begin
            n_sum = w_sum_sat;
        end
        if (i_cmd.eval) begin
            n_diff = DIFF_W'(r_sum) - DIFF_W'(r_cycle);
        end
        if (i_cmd.commit_wrap) begin
            n_timer  = r_diff[TIMER_W-1:0];
            n_cur    = r_next;
            n_next   = w_next_adv;
            n_weight = '0;
        end
        if (i_cmd.commit_zero) begin
            n_timer  = r_sum;
            n_weight = '0;
        end
        if (i_cmd.start_div) begin
            n_timer = r_sum;
            n_rem   = w_over[TIME_W-1:0];
            n_quot  = '0;
        end
        if (i_cmd.div_step) begin
            n_rem  = w_rem_step;
            n_quot = w_quot_step;
        end
        if (i_cmd.div_last) begin
            n_weight = {1'b0, w_quot_step};
        end

        if (w_load_out) begin
            n_out.blended_pixel = i_cmd.out_pixel ? w_lerp : '0;
            n_out.blend_weight  = n_weight;
            n_out.current_index = IDX_OUT_W'(n_cur);
            n_out.next_index    = IDX_OUT_W'(n_next);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle  <= CYCLE_RST;
            r_blend  <= BLEND_RST;
            r_fc     <= FCOUNT_RST;
            r_timer  <= '0;
            r_weight <= '0;
            r_cur    <= '0;
            r_next   <= (eff_count(FCOUNT_RST) > CNT_W'(1)) ? IDX_W'(1) : '0;
        end else begin
            r_cycle  <= n_cycle;
            r_blend  <= n_blend;
            r_fc     <= n_fc;
            r_timer  <= n_timer;
            r_weight <= n_weight;
            r_cur    <= n_cur;
            r_next   <= n_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum  <= n_sum;
        r_diff <= n_diff;
        r_rem  <= n_rem;
        r_quot <= n_quot;
        r_out  <= n_out;
    end

endmodule

`default_nettype wire

[hw/rtl/timed_frame_crossfade_blender.sv]
// ----------------------------------------------------------------------------
// Pixel items: result registered in the cycle after the transfer; one per cycle
// unless the output stalls. Tick items with one frame held behave alike; else
// S_EVAL, then S_OVER registers the result on a frame wrap or zero weight, else
// S_DIV runs the one-bit-per-cycle weight divider. Synchronous active-low reset
// restores the register defaults and restarts the animation at frame 0.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_frame_crossfade_blender import tfcb_pkg::*; #(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    tfcb_in_if.sink                    i_in,
    tfcb_out_if.source                 o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd      w_cmd;
    t_stat     w_stat;
    t_out_item w_out_data;
    logic      w_in_ready;
    logic      w_out_valid;

    tfcb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_func   (i_in.data.func),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    tfcb_datapath #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in.data),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out_data (w_out_data)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;
    assign o_out.data  = w_out_data;

endmodule

`default_nettype wire
